[rtl/core/sactag_pkg.sv]
// ----------------------------------------------------------------------------
// sactag_pkg
// Shared constants, state encoding and controller/datapath handshake types
// for the set-associative LRU tag store.
// ----------------------------------------------------------------------------
package sactag_pkg;

	// default sizing of the tag store
	localparam int MAX_INDEX_BITS_DEF = 10;
	localparam int MAX_WAYS_DEF       = 8;
	localparam int ADDR_BITS_DEF      = 64;

	// fixed field widths
	localparam int ADDR_W      = 64;
	localparam int CNT_W       = 32;
	localparam int STAMP_W     = 32;
	localparam int IDX_BITS_W  = 4;
	localparam int OFF_BITS_W  = 6;
	localparam int WAYS_W      = 4;
	localparam int WCNT_W      = 6;
	localparam int CFG_DATA_W  = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int IN_DATA_W   = 64;
	localparam int OUT_DATA_W  = 104;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

	// configuration reset values
	localparam logic [IDX_BITS_W-1:0] INDEX_BITS_RST  = 4'd1;
	localparam logic [OFF_BITS_W-1:0] OFFSET_BITS_RST = 6'd1;
	localparam logic [WAYS_W-1:0]     WAYS_RST        = 4'd1;

	// controller states
	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_UPD,
		ST_FIN
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic clr;
		logic load;
		logic rd;
		logic cmp;
		logic upd;
		logic out_load;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic clr_last;
		logic more;
		logic out_busy;
	} dp_sts_t;

endpackage

[rtl/core/sactag_ram.sv]
// ----------------------------------------------------------------------------
// sactag_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sactag_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/sactag_ctrl.sv]
// ----------------------------------------------------------------------------
// sactag_ctrl
// Sequencer: clearing pass after reset, then read, compare and write-back of
// one set per access, twice for a modify, then hand-off to the output register.
// ----------------------------------------------------------------------------
module sactag_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sactag_pkg::dp_sts_t sts,
	output sactag_pkg::dp_cmd_t cmd
);

	sactag_pkg::state_t state_q;
	sactag_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sactag_pkg::ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			sactag_pkg::ST_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = sactag_pkg::ST_IDLE;
				end
			end
			sactag_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = sactag_pkg::ST_RD;
				end
			end
			sactag_pkg::ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = sactag_pkg::ST_CMP;
			end
			sactag_pkg::ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = sactag_pkg::ST_UPD;
			end
			sactag_pkg::ST_UPD: begin
				cmd.upd = 1'b1;
				if (sts.more) begin
					state_d = sactag_pkg::ST_RD;
				end else begin
					state_d = sactag_pkg::ST_FIN;
				end
			end
			sactag_pkg::ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = sactag_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sactag_pkg::ST_CLR;
			end
		endcase
	end

endmodule

[rtl/core/sactag_dp.sv]
// ----------------------------------------------------------------------------
// sactag_dp
// Datapath: configuration registers, address split, set row memory, way
// compare, LRU victim tree, counters and the output register.
// ----------------------------------------------------------------------------
module sactag_dp #(
	parameter int MAX_INDEX_BITS = sactag_pkg::MAX_INDEX_BITS_DEF,
	parameter int MAX_WAYS       = sactag_pkg::MAX_WAYS_DEF,
	parameter int ADDR_BITS      = sactag_pkg::ADDR_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sactag_pkg::dp_cmd_t                 cmd,
	output sactag_pkg::dp_sts_t                 sts,
	input  logic                                cfg_we,
	input  logic [sactag_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sactag_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic [sactag_pkg::IN_DATA_W-1:0]    in_addr,
	input  logic                                in_func,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sactag_pkg::OUT_DATA_W-1:0]   out_data
);

	localparam int SET_W  = MAX_INDEX_BITS;
	localparam int TAG_W  = ADDR_BITS - 2;
	localparam int ST_W   = sactag_pkg::STAMP_W;
	localparam int ENT_W  = 1 + TAG_W + ST_W;
	localparam int ROW_W  = MAX_WAYS * ENT_W;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int NP     = 1 << WAY_W;
	localparam int SB_W   = $clog2(MAX_INDEX_BITS + 1);
	localparam int SUM_W  = 7;
	localparam int AW     = sactag_pkg::ADDR_W;
	localparam int CW     = sactag_pkg::CNT_W;
	localparam logic [AW-1:0] AMASK = (ADDR_BITS >= AW) ? {AW{1'b1}} :
		((AW'(1) << ADDR_BITS) - AW'(1));

	// configuration
	logic [sactag_pkg::IDX_BITS_W-1:0] index_bits_q;
	logic [sactag_pkg::OFF_BITS_W-1:0] offset_bits_q;
	logic [sactag_pkg::WAYS_W-1:0]     ways_q;

	// item state
	logic [SET_W-1:0] set_q;
	logic [TAG_W-1:0] tag_q;
	logic             func_q;
	logic             second_q;
	logic [SET_W-1:0] clr_idx_q;

	// compare stage
	logic [MAX_WAYS-1:0] match_q;
	logic [MAX_WAYS-1:0] inv_q;
	logic [ST_W-1:0]     age_q [MAX_WAYS];

	// counters and flags
	logic [ST_W-1:0] clock_q;
	logic [CW-1:0]   hits_q;
	logic [CW-1:0]   misses_q;
	logic [CW-1:0]   evict_q;
	logic            fhit_q;
	logic            fmiss_q;
	logic            fevict_q;

	// output register
	logic                              out_valid_q;
	logic [sactag_pkg::OUT_DATA_W-1:0] out_data_q;

	// row memory
	logic [ROW_W-1:0] row_rd;
	logic [ROW_W-1:0] row_new;
	logic             ram_we;
	logic [SET_W-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_wdata;

	// address split
	logic [SB_W-1:0]   sb_eff;
	logic [SUM_W-1:0]  tag_sh;
	logic [AW-1:0]     addr_m;
	logic [AW-1:0]     set_full;
	logic [AW-1:0]     tag_full;
	logic [SET_W-1:0]  set_mask;
	logic [sactag_pkg::WCNT_W-1:0] ways_eff;

	// update stage
	logic             up_hit;
	logic             inv_any;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] inv_way;
	logic [WAY_W-1:0] old_way;
	logic [WAY_W-1:0] pick;
	logic [ST_W-1:0]  t_age [2*NP-1];
	logic [WAY_W-1:0] t_way [2*NP-1];

	// configuration writes; writes to unused indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q  <= sactag_pkg::INDEX_BITS_RST;
			offset_bits_q <= sactag_pkg::OFFSET_BITS_RST;
			ways_q        <= sactag_pkg::WAYS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sactag_pkg::CFG_INDEX_BITS:  index_bits_q  <= cfg_wdata[3:0];
				sactag_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_wdata;
				sactag_pkg::CFG_WAYS_IN_USE: ways_q        <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// effective index bit count and associativity
	always_comb begin
		if (32'(index_bits_q) > 32'(MAX_INDEX_BITS)) begin
			sb_eff = SB_W'(MAX_INDEX_BITS);
		end else begin
			sb_eff = SB_W'(index_bits_q);
		end
		if (ways_q == '0) begin
			ways_eff = sactag_pkg::WCNT_W'(1);
		end else if (32'(ways_q) > 32'(MAX_WAYS)) begin
			ways_eff = sactag_pkg::WCNT_W'(MAX_WAYS);
		end else begin
			ways_eff = sactag_pkg::WCNT_W'(ways_q);
		end
	end

	// split the incoming address into set and tag
	always_comb begin
		addr_m   = in_addr & AMASK;
		set_mask = ~({SET_W{1'b1}} << sb_eff);
		set_full = addr_m >> offset_bits_q;
		tag_sh   = SUM_W'(offset_bits_q) + SUM_W'(sb_eff);
		tag_full = addr_m >> tag_sh;
	end

	// item registers and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q  <= 1'b0;
			clr_idx_q <= '0;
		end else begin
			if (cmd.clr) begin
				clr_idx_q <= clr_idx_q + SET_W'(1);
			end
			if (cmd.load) begin
				second_q <= 1'b0;
			end else if (cmd.upd) begin
				second_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			set_q  <= set_full[SET_W-1:0] & set_mask;
			tag_q  <= tag_full[TAG_W-1:0];
			func_q <= in_func;
		end
	end

	// row memory, one row per set
	sactag_ram #(
		.WIDTH(ROW_W),
		.DEPTH(1 << SET_W)
	) u_row_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd),
		.raddr(set_q),
		.rdata(row_rd)
	);

	assign ram_we    = cmd.clr | cmd.upd;
	assign ram_waddr = cmd.clr ? clr_idx_q : set_q;
	assign ram_wdata = cmd.clr ? '0 : row_new;

	// compare the ways of the row just read
	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			for (int w = 0; w < MAX_WAYS; w++) begin
				if (sactag_pkg::WCNT_W'(w) < ways_eff) begin
					match_q[w] <= row_rd[w*ENT_W] &&
						(row_rd[w*ENT_W+1 +: TAG_W] == tag_q);
					inv_q[w]   <= !row_rd[w*ENT_W];
					age_q[w]   <= clock_q - row_rd[w*ENT_W+1+TAG_W +: ST_W];
				end else begin
					match_q[w] <= 1'b0;
					inv_q[w]   <= 1'b0;
					age_q[w]   <= '0;
				end
			end
		end
	end

	// lowest matching and lowest invalid way
	always_comb begin
		hit_way = '0;
		inv_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match_q[w]) begin
				hit_way = WAY_W'(w);
			end
			if (inv_q[w]) begin
				inv_way = WAY_W'(w);
			end
		end
		up_hit  = |match_q;
		inv_any = |inv_q;
	end

	// oldest way: compare tree, left side wins a tie
	always_comb begin
		for (int i = 0; i < NP; i++) begin
			t_way[NP-1+i] = WAY_W'(i);
			if (i < MAX_WAYS) begin
				t_age[NP-1+i] = age_q[i];
			end else begin
				t_age[NP-1+i] = '0;
			end
		end
		for (int n = NP - 2; n >= 0; n--) begin
			if (t_age[2*n+2] > t_age[2*n+1]) begin
				t_age[n] = t_age[2*n+2];
				t_way[n] = t_way[2*n+2];
			end else begin
				t_age[n] = t_age[2*n+1];
				t_way[n] = t_way[2*n+1];
			end
		end
		old_way = t_way[0];
	end

	// chosen way and the row written back
	always_comb begin
		if (up_hit) begin
			pick = hit_way;
		end else if (inv_any) begin
			pick = inv_way;
		end else begin
			pick = old_way;
		end
		row_new = row_rd;
		row_new[32'(pick)*ENT_W +: ENT_W] = {clock_q, tag_q, 1'b1};
	end

	// stamp clock, totals and first-access flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q  <= '0;
			hits_q   <= '0;
			misses_q <= '0;
			evict_q  <= '0;
			fhit_q   <= 1'b0;
			fmiss_q  <= 1'b0;
			fevict_q <= 1'b0;
		end else begin
			if (cmd.rd) begin
				clock_q <= clock_q + ST_W'(1);
			end
			if (cmd.upd) begin
				if (up_hit) begin
					hits_q <= hits_q + CW'(1);
				end else begin
					misses_q <= misses_q + CW'(1);
					if (!inv_any) begin
						evict_q <= evict_q + CW'(1);
					end
				end
				if (!second_q) begin
					fhit_q   <= up_hit;
					fmiss_q  <= !up_hit;
					fevict_q <= !up_hit && !inv_any;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {5'b0, evict_q, misses_q, hits_q, fevict_q, fmiss_q, fhit_q};
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;
	assign sts.clr_last = &clr_idx_q;
	assign sts.more     = func_q & ~second_q;
	assign sts.out_busy = out_valid_q & ~out_ready;

	// a hit bumps the hit total by one
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd && up_hit) |=> (hits_q == $past(hits_q) + CW'(1)))
		else $error("hit total did not advance on a hit");

	// a miss with no free way bumps the eviction total
	a_evict_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd && !up_hit && !inv_any) |=> (evict_q == $past(evict_q) + CW'(1)))
		else $error("eviction total did not advance on an eviction");

	// first-access flags are consistent in a delivered item
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_data_q[0] != out_data_q[1]) &&
			(!out_data_q[2] || out_data_q[1])))
		else $error("inconsistent hit, miss and eviction flags");

endmodule

[rtl/core/set_assoc_cache_lru_tag_store.sv]
// Flow: an accepted item is read, compared and written back, twice for a modify, then
//   loaded into the output register; a new item is taken only after that load. Each
//   access is a row read, a way compare and a row write-back on the single set memory.
// Reset: asynchronous; a clearing pass then sweeps every row of the set memory with
//   s_tready low; configuration writes are taken during it.
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tag_store
// Tag store of a set-associative cache with true LRU replacement, giving
// hit, miss and eviction flags of the first access and running totals.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_tag_store #(
	parameter int MAX_INDEX_BITS = sactag_pkg::MAX_INDEX_BITS_DEF,
	parameter int MAX_WAYS       = sactag_pkg::MAX_WAYS_DEF,
	parameter int ADDR_BITS      = sactag_pkg::ADDR_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [sactag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sactag_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// input items
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sactag_pkg::IN_DATA_W-1:0]  s_tdata,  // address
	input  logic [0:0]                        s_tuser,  // func
	// result items
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// first_hit, first_miss, first_evicted, hits_total, misses_total,
	// evictions_total, zero fill
	output logic [sactag_pkg::OUT_DATA_W-1:0] m_tdata
);

	sactag_pkg::dp_cmd_t cmd;
	sactag_pkg::dp_sts_t sts;

	// controller
	sactag_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// datapath
	sactag_dp #(
		.MAX_INDEX_BITS(MAX_INDEX_BITS),
		.MAX_WAYS      (MAX_WAYS),
		.ADDR_BITS     (ADDR_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_addr  (s_tdata),
		.in_func  (s_tuser[0]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata)
	);

endmodule

[sim/tb_set_assoc_cache_lru_tag_store.sv]
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_tag_store
// Self-checking bench for the LRU tag store. A local model of the sets,
// stamps and totals predicts each result. Directed accesses cover the split
// extremes, tag aliasing and LRU order. Random traffic follows, mostly on
// small working sets, under random stalls on both sides and one long
// output stall.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lru_tag_store;
	import sactag_pkg::*;

	localparam int MAX_IDX = MAX_INDEX_BITS_DEF;
	localparam int MAX_W   = MAX_WAYS_DEF;
	localparam int LINES   = MAX_W << MAX_IDX;

	localparam logic FUNC_SINGLE = 1'b0;
	localparam logic FUNC_MODIFY = 1'b1;

	typedef struct {
		logic        hit;
		logic        miss;
		logic        evicted;
		logic [31:0] hits;
		logic [31:0] misses;
		logic [31:0] evictions;
	} outcome_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;  // address
	logic [0:0]            s_tuser   = '0;  // func
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// first_hit, first_miss, first_evicted, hits_total, misses_total,
	// evictions_total, zero fill
	logic [OUT_DATA_W-1:0] m_tdata;

	// model of the tag store
	bit          line_live  [LINES];
	logic [61:0] line_tagv  [LINES];
	logic [31:0] line_stamp [LINES];
	logic [31:0] lru_clock;
	logic [31:0] hit_total;
	logic [31:0] miss_total;
	logic [31:0] evict_total;
	logic [3:0]  idx_bits_r;
	logic [5:0]  off_bits_r;
	logic [3:0]  ways_r;

	outcome_t    pending_outcomes [$];
	int unsigned error_count;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_left;

	set_assoc_cache_lru_tag_store dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// one access against the model sets
	function automatic void lru_access(input logic [63:0] addr,
			output logic hit, output logic miss, output logic evict);
		int unsigned sb;
		int unsigned ways;
		int unsigned ob;
		int unsigned base;
		int unsigned pick;
		logic [63:0] set_no;
		logic [63:0] tag;
		logic [31:0] best_age;
		logic [31:0] age;
		sb = (idx_bits_r > MAX_IDX) ? MAX_IDX : idx_bits_r;
		ways = (ways_r == 0) ? 1 : ways_r;
		if (ways > MAX_W)
			ways = MAX_W;
		ob = off_bits_r;
		hit = 1'b0;
		miss = 1'b0;
		evict = 1'b0;
		lru_clock = lru_clock + 32'd1;
		set_no = '0;
		tag = '0;
		if (ob < 64)
			set_no = (addr >> ob) & ((64'd1 << sb) - 64'd1);
		if (ob + sb < 64)
			tag = addr >> (ob + sb);
		tag[63:62] = 2'b00;
		base = int'(set_no) * MAX_W;
		// lookup
		for (int w = 0; w < ways; w++) begin
			if (line_live[base + w] && line_tagv[base + w] == tag[61:0]) begin
				hit_total = hit_total + 32'd1;
				line_stamp[base + w] = lru_clock;
				hit = 1'b1;
				return;
			end
		end
		miss_total = miss_total + 32'd1;
		miss = 1'b1;
		// fill the lowest free way
		for (int w = 0; w < ways; w++) begin
			if (!line_live[base + w]) begin
				line_live[base + w] = 1'b1;
				line_tagv[base + w] = tag[61:0];
				line_stamp[base + w] = lru_clock;
				return;
			end
		end
		// evict the oldest, lowest way on a tie
		evict_total = evict_total + 32'd1;
		evict = 1'b1;
		pick = 0;
		best_age = lru_clock - line_stamp[base];
		for (int w = 1; w < ways; w++) begin
			age = lru_clock - line_stamp[base + w];
			if (age > best_age) begin
				best_age = age;
				pick = w;
			end
		end
		line_tagv[base + pick] = tag[61:0];
		line_stamp[base + pick] = lru_clock;
	endfunction

	// expected result of one accepted item
	function automatic void predict_outcome(input logic func, input logic [63:0] addr);
		outcome_t o;
		logic     h2;
		logic     m2;
		logic     e2;
		lru_access(addr, o.hit, o.miss, o.evicted);
		if (func == FUNC_MODIFY)
			lru_access(addr, h2, m2, e2);
		o.hits = hit_total;
		o.misses = miss_total;
		o.evictions = evict_total;
		pending_outcomes.push_back(o);
	endfunction

	function automatic void note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want)
			note_error($sformatf("%s expected %0h got %0h", name, want, got));
	endfunction

	// result checking
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_outcomes.size() == 0) begin
				note_error($sformatf("result %h with no item outstanding", m_tdata));
			end else begin
				want = pending_outcomes.pop_front();
				check_field("first_hit", want.hit, m_tdata[0]);
				check_field("first_miss", want.miss, m_tdata[1]);
				check_field("first_evicted", want.evicted, m_tdata[2]);
				check_field("hits_total", want.hits, m_tdata[34:3]);
				check_field("misses_total", want.misses, m_tdata[66:35]);
				check_field("evictions_total", want.evictions, m_tdata[98:67]);
			end
		end
	end

	// output back-pressure, with a long hold when asked
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else begin
			m_tready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// offer one item and wait until it is taken
	task automatic send_access(input logic func, input logic [63:0] addr);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = func;
		s_tdata = addr;
		do @(posedge clk); while (!s_tready);
		predict_outcome(func, addr);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [5:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(posedge clk);
		case (idx)
			CFG_INDEX_BITS:  idx_bits_r = val[3:0];
			CFG_OFFSET_BITS: off_bits_r = val;
			CFG_WAYS_IN_USE: ways_r = val[3:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// new split and associativity, only with the block idle
	task automatic set_geometry(input logic [5:0] idx_bits, input logic [5:0] off_bits,
			input logic [5:0] ways);
		drain_results();
		write_reg(CFG_INDEX_BITS, idx_bits);
		write_reg(CFG_OFFSET_BITS, off_bits);
		write_reg(CFG_WAYS_IN_USE, ways);
	endtask

	// reset geometry: two sets, one way, one offset bit
	task automatic test_reset_defaults();
		send_access(FUNC_SINGLE, 64'h0);
		send_access(FUNC_SINGLE, 64'h0);
		send_access(FUNC_SINGLE, 64'h1);
		send_access(FUNC_SINGLE, 64'h2);
		send_access(FUNC_SINGLE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_access(FUNC_MODIFY, 64'h8000_0000_0000_0000);
	endtask

	// offset and index reaching the top of the address, saturated settings
	task automatic test_wide_split();
		set_geometry(6'd15, 6'd63, 6'd15);
		send_access(FUNC_SINGLE, 64'h0);
		send_access(FUNC_SINGLE, 64'h8000_0000_0000_0000);
		send_access(FUNC_SINGLE, 64'h7FFF_FFFF_FFFF_FFFF);
		send_access(FUNC_SINGLE, 64'hFFFF_FFFF_FFFF_FFFF);
		set_geometry(6'd10, 6'd32, 6'd8);
		send_access(FUNC_SINGLE, 64'h0000_03FF_0000_0000);
		send_access(FUNC_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	// single set, no offset: top tag bits dropped so addresses alias
	task automatic test_tag_alias();
		set_geometry(6'd0, 6'd0, 6'd0);
		send_access(FUNC_SINGLE, 64'h0);
		send_access(FUNC_SINGLE, 64'hC000_0000_0000_0000);
		send_access(FUNC_SINGLE, 64'h4000_0000_0000_0000);
		send_access(FUNC_SINGLE, 64'h1);
		send_access(FUNC_MODIFY, 64'h2);
	endtask

	// four ways in set 0, replacement follows recency
	task automatic test_lru_order();
		set_geometry(6'd1, 6'd4, 6'd4);
		for (int t = 1; t <= 4; t++)
			send_access(FUNC_SINGLE, 64'(t) << 5);
		send_access(FUNC_SINGLE, 64'd1 << 5);
		send_access(FUNC_SINGLE, 64'd5 << 5);
		send_access(FUNC_SINGLE, 64'd2 << 5);
		send_access(FUNC_MODIFY, 64'd1 << 5);
		send_access(FUNC_SINGLE, 64'd6 << 5);
	endtask

	// random geometry, traffic mostly on a small working set
	task automatic test_random_traffic(input int unsigned items);
		logic [5:0]  idx_bits;
		logic [5:0]  off_bits;
		logic [5:0]  ways;
		logic [63:0] hot [24];
		logic [63:0] addr;
		int unsigned hot_n;
		idx_bits = ($urandom_range(9) == 0) ? 6'($urandom_range(6, 15)) : 6'($urandom_range(5));
		off_bits = ($urandom_range(9) == 0) ? 6'($urandom_range(40, 63)) : 6'($urandom_range(12));
		ways = 6'($urandom_range(9));
		set_geometry(idx_bits, off_bits, ways);
		hot_n = $urandom_range(4, 24);
		foreach (hot[i])
			hot[i] = {$urandom, $urandom};
		repeat (items) begin
			if ($urandom_range(9) < 2)
				addr = {$urandom, $urandom};
			else
				addr = hot[$urandom_range(hot_n - 1)]
					^ ({$urandom, $urandom} & ((64'd1 << off_bits) - 64'd1));
			send_access(logic'($urandom_range(1)), addr);
		end
	endtask

	// long output stall while items keep coming
	task automatic test_output_stall();
		hold_left = 300;
		repeat (20)
			send_access(logic'($urandom_range(1)), {$urandom, $urandom});
	endtask

	initial begin
		lru_clock = '0;
		hit_total = '0;
		miss_total = '0;
		evict_total = '0;
		idx_bits_r = INDEX_BITS_RST;
		off_bits_r = OFFSET_BITS_RST;
		ways_r = WAYS_RST;
		error_count = 0;
		hold_left = 0;
		send_idle_pct = 37;
		recv_idle_pct = 83;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_wide_split();
		test_tag_alias();
		test_lru_order();
		test_random_traffic(215);
		test_random_traffic(215);

		send_idle_pct = 83;
		recv_idle_pct = 37;
		test_random_traffic(215);
		test_random_traffic(215);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_output_stall();
		test_random_traffic(200);
		test_random_traffic(215);

		drain_results();
		repeat (16) @(posedge clk);
		error_count += pending_outcomes.size();
		if (error_count == 0)
			$display("tb_set_assoc_cache_lru_tag_store: done, clean");
		else
			$display("tb_set_assoc_cache_lru_tag_store: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#(8 * 500000);
		$display("tb_set_assoc_cache_lru_tag_store: done, errors");
		$finish;
	end

endmodule
